// ===== rtl/kdpr_pkg.sv =====
// kdpr_pkg: shared constants, codes and types for the key debouncer
// with auto-repeat; no dependencies
package kdpr_pkg;

   localparam int NUM_KEYS = 6;
   localparam int LEVEL_W  = 6;
   localparam int KEY_W    = 3;
   localparam int CNT_W    = 6;
   localparam int HOLD_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CNT_W-1:0]  ON_TIME_RESET       = 6'd5;
   localparam logic [HOLD_W-1:0] REPEAT_START_RESET  = 8'd250;
   localparam logic [HOLD_W-1:0] REPEAT_PERIOD_RESET = 8'd20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_TIME       = 2'd0,
      CSR_REPEAT_START  = 2'd1,
      CSR_REPEAT_PERIOD = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_TICK   = 1'b1
   } command_type;

   // what one key found for the current transaction
   typedef struct packed {
      logic push;
      logic pull;
      logic rpt;
   } lane_event_type;

   // merged result of one transaction
   typedef struct packed {
      logic             push_valid;
      logic [KEY_W-1:0] push_key;
      logic             pull_valid;
      logic [KEY_W-1:0] pull_key;
      logic             repeat_valid;
      logic [KEY_W-1:0] repeat_key;
   } result_type;

endpackage

// ===== rtl/kdpr_if.sv =====
// kdpr_req_if / kdpr_rsp_if: valid-ready channels of the debouncer
// depends on kdpr_pkg
interface kdpr_req_if
   import kdpr_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              command;
   logic [LEVEL_W-1:0] key_levels;

   modport source (output valid, command, key_levels, input ready);
   modport sink   (input valid, command, key_levels, output ready);
endinterface

interface kdpr_rsp_if
   import kdpr_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             push_valid;
   logic [KEY_W-1:0] push_key;
   logic             pull_valid;
   logic [KEY_W-1:0] pull_key;
   logic             repeat_valid;
   logic [KEY_W-1:0] repeat_key;

   modport source (output valid, push_valid, push_key, pull_valid, pull_key,
                   repeat_valid, repeat_key, input ready);
   modport sink   (input valid, push_valid, push_key, pull_valid, pull_key,
                   repeat_valid, repeat_key, output ready);
endinterface

// ===== rtl/kdpr_lane.sv =====
// kdpr_lane: debounce counter, on/edge state and hold counter of one key
// depends on kdpr_pkg
module kdpr_lane
   import kdpr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              command,
   input  logic              level,
   input  logic [CNT_W-1:0]  on_time,
   input  logic [HOLD_W-1:0] repeat_start,
   input  logic [HOLD_W-1:0] repeat_period,
   output lane_event_type    event_out
);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              on_ff, on_in;
   logic              edge_ff, edge_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [HOLD_W-1:0] hold_inc;

   always_comb begin
      count_in  = count_ff;
      on_in     = on_ff;
      edge_in   = edge_ff;
      hold_in   = hold_ff;
      event_out = '0;
      hold_inc  = hold_ff + 8'd1;
      if (command == CMD_SAMPLE) begin
         if (level) begin
            // released: count down toward zero
            count_in = (count_ff != '0) ? count_ff - 6'd1 : count_ff;
            if (count_in == '0) begin
               if (on_ff) begin
                  on_in          = 1'b0;
                  edge_in        = 1'b1;
                  event_out.pull = 1'b1;
               end else begin
                  edge_in = 1'b0;
               end
            end
         end else begin
            // pressed: count up to on_time, no further
            count_in = (count_ff < on_time) ? count_ff + 6'd1 : count_ff;
            if (count_in >= on_time) begin
               if (!on_ff) begin
                  on_in          = 1'b1;
                  edge_in        = 1'b1;
                  event_out.push = 1'b1;
               end else begin
                  edge_in = 1'b0;
               end
            end
         end
      end else begin
         if (on_ff && !edge_ff) begin
            hold_in = hold_inc;
            if (hold_inc == repeat_start) begin
               event_out.rpt = 1'b1;
               hold_in = (hold_inc >= repeat_period) ? hold_inc - repeat_period : '0;
            end
         end else begin
            hold_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         on_ff    <= 1'b0;
         edge_ff  <= 1'b0;
         hold_ff  <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         on_ff    <= on_in;
         edge_ff  <= edge_in;
         hold_ff  <= hold_in;
      end
   end

endmodule

// ===== rtl/kdpr_merge.sv =====
// kdpr_merge: picks the highest key index for each event kind
// depends on kdpr_pkg
module kdpr_merge
   import kdpr_pkg::*;
(
   input  lane_event_type events [NUM_KEYS],
   output result_type     result
);

   always_comb begin
      result = '0;
      // later keys overwrite earlier ones, so the highest index wins
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (events[k].push) begin
            result.push_valid = 1'b1;
            result.push_key   = k[KEY_W-1:0];
         end
         if (events[k].pull) begin
            result.pull_valid = 1'b1;
            result.pull_key   = k[KEY_W-1:0];
         end
         if (events[k].rpt) begin
            result.repeat_valid = 1'b1;
            result.repeat_key   = k[KEY_W-1:0];
         end
      end
   end

endmodule

// ===== rtl/key_debounce_push_pull_repeat_core.sv =====
// key_debounce_push_pull_repeat_core: top level of the key debouncer
// depends on kdpr_pkg, kdpr_if, kdpr_lane, kdpr_merge
// the result is registered and shows in the cycle after the transaction is accepted
// throughput: one transaction per cycle unless the response stalls; lanes update
// on accept and the single output register refills while its result is taken
// reset: synchronous, clears all key state and loads register defaults
module key_debounce_push_pull_repeat_core
   import kdpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   kdpr_req_if.sink              req_chan,
   kdpr_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [CNT_W-1:0]  on_time_ff;
   logic [HOLD_W-1:0] repeat_start_ff;
   logic [HOLD_W-1:0] repeat_period_ff;

   // output register
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   logic           accept;
   lane_event_type events [NUM_KEYS];
   result_type     merged;

   // take a new transaction whenever the output slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_time_ff       <= ON_TIME_RESET;
         repeat_start_ff  <= REPEAT_START_RESET;
         repeat_period_ff <= REPEAT_PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ON_TIME:       on_time_ff       <= csr_wdata[CNT_W-1:0];
            CSR_REPEAT_START:  repeat_start_ff  <= csr_wdata[HOLD_W-1:0];
            CSR_REPEAT_PERIOD: repeat_period_ff <= csr_wdata[HOLD_W-1:0];
            default: ;  // unmapped index, write ignored
         endcase
      end
   end

   // one lane per key; keys past the pin field read as released
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      logic level;
      if (k < LEVEL_W) begin : g_pin
         assign level = req_chan.key_levels[k];
      end else begin : g_nopin
         assign level = 1'b1;
      end

      kdpr_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .accept        (accept),
         .command       (req_chan.command),
         .level         (level),
         .on_time       (on_time_ff),
         .repeat_start  (repeat_start_ff),
         .repeat_period (repeat_period_ff),
         .event_out     (events[k])
      );
   end

   kdpr_merge u_merge (
      .events (events),
      .result (merged)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.push_valid   = rsp_data_ff.push_valid;
   assign rsp_chan.push_key     = rsp_data_ff.push_key;
   assign rsp_chan.pull_valid   = rsp_data_ff.pull_valid;
   assign rsp_chan.pull_key     = rsp_data_ff.pull_key;
   assign rsp_chan.repeat_valid = rsp_data_ff.repeat_valid;
   assign rsp_chan.repeat_key   = rsp_data_ff.repeat_key;

endmodule

// ===== rtl/kdpr_checker.sv =====
// kdpr_port_checker: port-level assertions for the key debouncer, bound to the top
// depends on kdpr_pkg and key_debounce_push_pull_repeat_core
module kdpr_port_checker
   import kdpr_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_command,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             push_valid,
   input logic [KEY_W-1:0] push_key,
   input logic             pull_valid,
   input logic [KEY_W-1:0] pull_key,
   input logic             repeat_valid,
   input logic [KEY_W-1:0] repeat_key
);

   // stalled result stays valid and keeps its key fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(push_key) && $stable(pull_key)
         && $stable(repeat_key))
      else $error("stalled result changed");

   // key fields are zero when their event is absent
   a_idle_keys: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (push_valid || push_key == '0) && (pull_valid || pull_key == '0)
         && (repeat_valid || repeat_key == '0))
      else $error("key index set without event");

   // a tick transaction yields no push or pull
   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_TICK |=>
         rsp_valid && !push_valid && !pull_valid)
      else $error("tick produced push or pull");

   // a sample transaction yields no repeat
   a_sample_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_SAMPLE |=> rsp_valid && !repeat_valid)
      else $error("sample produced repeat");

   // one key cannot be pushed and pulled in the same transaction
   a_push_pull: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && push_valid && pull_valid |-> push_key != pull_key)
      else $error("same key pushed and pulled");

endmodule

bind key_debounce_push_pull_repeat_core kdpr_port_checker u_kdpr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_command  (req_chan.command),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .push_valid   (rsp_chan.push_valid),
   .push_key     (rsp_chan.push_key),
   .pull_valid   (rsp_chan.pull_valid),
   .pull_key     (rsp_chan.pull_key),
   .repeat_valid (rsp_chan.repeat_valid),
   .repeat_key   (rsp_chan.repeat_key)
);

// ===== sim/kdpr_checker.sv =====
// kdpr_checker: watches the request, response and register ports of the
// key debouncer, predicts each response and compares it field by field
// depends on kdpr_pkg and kdpr_if
module kdpr_checker
   import kdpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   kdpr_req_if                   req_mon,
   kdpr_rsp_if                   rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_count,
   output int                    checked_count,
   output int                    push_count,
   output int                    pull_count,
   output int                    repeat_count
);

   logic [CNT_W-1:0]  on_time_cfg;
   logic [HOLD_W-1:0] rpt_start_cfg;
   logic [HOLD_W-1:0] rpt_period_cfg;

   logic [CNT_W-1:0]  integ_count [NUM_KEYS];
   logic              key_on      [NUM_KEYS];
   logic              key_edge    [NUM_KEYS];
   logic [HOLD_W-1:0] hold_ticks  [NUM_KEYS];

   result_type expected_results [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] transaction %0d: %s got %0d expected %0d",
               $time, checked_count, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [KEY_W-1:0] got,
                              input logic [KEY_W-1:0] want);
      if (got !== want) begin
         report_mismatch(what, int'(got), int'(want));
      end
   endtask

   // advances the per-key debounce and hold state by one transaction
   function automatic result_type predict_key_events(input command_type cmd,
                                                     input logic [LEVEL_W-1:0] levels);
      result_type        r;
      logic [CNT_W-1:0]  c;
      logic [HOLD_W-1:0] h;
      logic              released;
      r = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (cmd == CMD_SAMPLE) begin
            released = (k >= LEVEL_W) ? 1'b1 : levels[k];
            c = integ_count[k];
            if (released) begin
               if (c != '0) c = c - 1'b1;
               if (c == '0) begin
                  if (key_on[k]) begin
                     key_on[k]   = 1'b0;
                     key_edge[k] = 1'b1;
                     r.pull_valid = 1'b1;
                     r.pull_key   = KEY_W'(k);
                  end else begin
                     key_edge[k] = 1'b0;
                  end
               end
            end else begin
               if (c < on_time_cfg) c = c + 1'b1;
               if (c >= on_time_cfg) begin
                  if (!key_on[k]) begin
                     key_on[k]   = 1'b1;
                     key_edge[k] = 1'b1;
                     r.push_valid = 1'b1;
                     r.push_key   = KEY_W'(k);
                  end else begin
                     key_edge[k] = 1'b0;
                  end
               end
            end
            integ_count[k] = c;
         end else begin
            if (key_on[k] && !key_edge[k]) begin
               h = hold_ticks[k] + 1'b1;
               if (h == rpt_start_cfg) begin
                  r.repeat_valid = 1'b1;
                  r.repeat_key   = KEY_W'(k);
                  h = (h >= rpt_period_cfg) ? h - rpt_period_cfg : '0;
               end
               hold_ticks[k] = h;
            end else begin
               hold_ticks[k] = '0;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         on_time_cfg    = ON_TIME_RESET;
         rpt_start_cfg  = REPEAT_START_RESET;
         rpt_period_cfg = REPEAT_PERIOD_RESET;
         for (int k = 0; k < NUM_KEYS; k++) begin
            integ_count[k] = '0;
            key_on[k]      = 1'b0;
            key_edge[k]    = 1'b0;
            hold_ticks[k]  = '0;
         end
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("response with nothing outstanding", 1, 0);
            end else begin
               want = expected_results.pop_front();
               check_field("push_valid", KEY_W'(rsp_mon.push_valid), KEY_W'(want.push_valid));
               check_field("push_key", rsp_mon.push_key, want.push_key);
               check_field("pull_valid", KEY_W'(rsp_mon.pull_valid), KEY_W'(want.pull_valid));
               check_field("pull_key", rsp_mon.pull_key, want.pull_key);
               check_field("repeat_valid", KEY_W'(rsp_mon.repeat_valid),
                           KEY_W'(want.repeat_valid));
               check_field("repeat_key", rsp_mon.repeat_key, want.repeat_key);
               push_count   += want.push_valid;
               pull_count   += want.pull_valid;
               repeat_count += want.repeat_valid;
            end
            checked_count++;
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(
               predict_key_events(command_type'(req_mon.command), req_mon.key_levels));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ON_TIME:       on_time_cfg    = csr_wdata[CNT_W-1:0];
               CSR_REPEAT_START:  rpt_start_cfg  = csr_wdata[HOLD_W-1:0];
               CSR_REPEAT_PERIOD: rpt_period_cfg = csr_wdata[HOLD_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== sim/key_debounce_push_pull_repeat_core_test.sv =====
// key_debounce_push_pull_repeat_core_test: stimulus and verdict for the
// key debouncer; the kdpr_checker instance does prediction and comparison
// depends on kdpr_pkg, kdpr_if, kdpr_checker and the core
module key_debounce_push_pull_repeat_core_test;
   import kdpr_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 4;   // margin past the registered response

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   kdpr_req_if req_if ();
   kdpr_rsp_if rsp_if ();

   int error_count, pending_count, checked_count;
   int push_count, pull_count, repeat_count;
   int cycle_count = 0;
   int sent_count = 0;
   int phase_count = 0;

   // idle percentages of the two sides, changed between phases
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // intended key levels that the random samples bounce around
   logic [LEVEL_W-1:0] held_levels = '1;
   int                 run_left = 0;

   key_debounce_push_pull_repeat_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   kdpr_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .push_count    (push_count),
      .pull_count    (pull_count),
      .repeat_count  (repeat_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // response side stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // hang guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d transactions outstanding",
               cycle_count, pending_count);
      $display("CHECKS FAILED");
      $finish;
   end

   // one transaction, with random idle cycles in front of it; valid stays
   // high when the next transaction follows without a gap
   task automatic send_item(input command_type cmd, input logic [LEVEL_W-1:0] levels);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.command    <= cmd;
      req_if.key_levels <= levels;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_count++;
   endtask

   // drop valid and wait until every response is back
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // only called while the core is idle
   task automatic load_settings(input logic [CNT_W-1:0] on_time,
                                input logic [HOLD_W-1:0] rpt_start,
                                input logic [HOLD_W-1:0] rpt_period);
      write_csr(CSR_ON_TIME, CSR_DATA_W'(on_time));
      write_csr(CSR_REPEAT_START, rpt_start);
      write_csr(CSR_REPEAT_PERIOD, rpt_period);
      csr_we <= 1'b0;
   endtask

   // mostly steady key levels with short bounces, mixed with repeat ticks;
   // a small share of samples is pure noise
   task automatic random_phase(input int n_items, input int tick_pct, input int run_max,
                               input int bounce_pct);
      logic [LEVEL_W-1:0] levels;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < tick_pct) begin
            // levels are ignored on a tick, so they carry junk
            send_item(CMD_TICK, LEVEL_W'($urandom));
         end else begin
            if (run_left == 0) begin
               if ($urandom_range(3) == 0) begin
                  held_levels = LEVEL_W'($urandom);
               end else begin
                  held_levels ^= LEVEL_W'(1 << $urandom_range(LEVEL_W-1));
               end
               run_left = $urandom_range(1, run_max);
            end
            run_left--;
            levels = held_levels;
            if ($urandom_range(99) < bounce_pct) begin
               levels ^= LEVEL_W'(1 << $urandom_range(LEVEL_W-1));
            end
            if ($urandom_range(99) < 3) begin
               levels = LEVEL_W'($urandom);
            end
            send_item(CMD_SAMPLE, levels);
         end
      end
      drain();
      phase_count++;
   endtask

   initial begin
      // every input known from time zero
      req_if.valid      = 1'b0;
      req_if.command    = CMD_SAMPLE;
      req_if.key_levels = '1;
      csr_we            = 1'b0;
      csr_index         = CSR_ON_TIME;
      csr_wdata         = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles rarely, receiver often
      send_idle_pct = 29;
      recv_idle_pct = 72;

      // directed: short debounce, repeat period longer than the start
      load_settings(6'd2, 8'd3, 8'd5);
      send_item(CMD_SAMPLE, 6'h3F);   // released at zero while off
      send_item(CMD_SAMPLE, 6'h00);
      send_item(CMD_SAMPLE, 6'h00);   // push on all keys, key 5 reported
      send_item(CMD_SAMPLE, 6'h00);   // pressed at threshold while on
      send_item(CMD_TICK,   6'h00);
      send_item(CMD_TICK,   6'h3F);
      send_item(CMD_TICK,   6'h15);   // repeat, hold count clamps to zero
      send_item(CMD_SAMPLE, 6'h3E);
      send_item(CMD_SAMPLE, 6'h3E);   // pull on keys 1 to 5
      send_item(CMD_SAMPLE, 6'h3E);   // released and already off
      send_item(CMD_TICK,   6'h2A);   // key 0 steady on, others idle
      send_item(CMD_SAMPLE, 6'h15);
      send_item(CMD_SAMPLE, 6'h2A);
      send_item(CMD_SAMPLE, 6'h15);
      send_item(CMD_SAMPLE, 6'h15);
      send_item(CMD_TICK,   6'h00);
      send_item(CMD_TICK,   6'h3F);
      send_item(CMD_SAMPLE, 6'h3F);
      send_item(CMD_SAMPLE, 6'h3F);
      send_item(CMD_SAMPLE, 6'h3F);
      drain();
      phase_count++;

      // all settings at one: every steady tick repeats
      load_settings(6'd1, 8'd1, 8'd1);
      random_phase(110, 35, 8, 15);

      // highest settings: long presses needed, long runs of steady levels
      load_settings(6'd63, 8'd255, 8'd255);
      random_phase(130, 20, 134, 4);

      // receiver idles rarely, sender often
      send_idle_pct = 72;
      recv_idle_pct = 29;

      // on_time lowered below counters left near the top
      load_settings(6'd3, 8'd40, 8'd7);
      random_phase(100, 30, 20, 10);

      // long steady holds build up large hold counts
      load_settings(6'd2, 8'd200, 8'd100);
      random_phase(120, 70, 200, 3);

      // repeat start lowered under those counts: they wrap and count again
      load_settings(6'd2, 8'd10, 8'd3);
      random_phase(100, 50, 60, 5);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;

      // zero on_time, and a period larger than the start
      load_settings(6'd0, 8'd5, 8'd9);
      random_phase(80, 35, 6, 20);

      load_settings(6'd4, 8'd17, 8'd6);
      random_phase(160, 40, 30, 8);

      $display("covered %0d transactions over %0d register settings, %0d responses checked",
               sent_count, phase_count, checked_count);
      $display("key events: %0d pushes, %0d pulls, %0d repeats",
               push_count, pull_count, repeat_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
